// ===== rtl/gctw_pkg.sv =====
// ----------------------------------------------------------------------------
// gctw_pkg: shared types, constants and tables
// Stage payloads, calendar constants and small lookup functions used by the
// GPS calendar to week / time-of-week pipeline.
// ----------------------------------------------------------------------------
package gctw_pkg;

  // Field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int MILLIS_W = 16;
  localparam int WEEK_W   = 14;
  localparam int TOW_W    = 30;

  // Internal widths
  localparam int EPD_W   = 20;  // days since epoch, covers year 4095
  localparam int TOD_W   = 27;  // time of day in ms, below 86401000
  localparam int DIY_W   = 9;   // day within year, up to 366
  localparam int WQ_W    = 18;  // quotient of days / 7
  localparam int Q100_W  = 6;   // year / 100
  localparam int LEAP_W  = 11;  // leap year count, with headroom

  // Default year limit
  localparam int MAX_YEAR_DEF = 2235;

  // Calendar constants
  localparam logic [YEAR_W-1:0]   EPOCH_YEAR  = 12'd1980;
  localparam logic [MILLIS_W-1:0] MS_LIMIT    = 16'd61000;
  localparam logic [LEAP_W-1:0]   LEAPS_EPOCH = 11'd479;  // leap years in 1..1979
  localparam logic [EPD_W-1:0]    EPOCH_DAY   = 20'd6;    // 1980-01-06 is day zero
  localparam logic [EPD_W-1:0]    DAYS_YEAR   = 20'd365;
  localparam logic [MONTH_W-1:0]  MONTH_DEC   = 4'd12;
  localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
  localparam logic [HOUR_W-1:0]   HOUR_MAX    = 5'd23;
  localparam logic [MINUTE_W-1:0] MINUTE_MAX  = 6'd59;

  localparam logic [TOD_W-1:0] MS_PER_HOUR = 27'd3600000;
  localparam logic [TOD_W-1:0] MS_PER_MIN  = 27'd60000;

  // Reciprocal constants: x / 100 = (x * 5243) >> 19 for x below 4096,
  // x / 7 = (x * 1198373) >> 23 for x below 2^21.
  localparam int                DIV100_SHIFT = 19;
  localparam logic [12:0]       DIV100_MUL   = 13'd5243;
  localparam logic [6:0]        HUNDRED      = 7'd100;
  localparam int                DIV7_SHIFT   = 23;
  localparam int                DIV7_MUL_W   = 21;
  localparam logic [DIV7_MUL_W-1:0] DIV7_MUL = 21'd1198373;
  localparam int                PROD7_W      = EPD_W + DIV7_MUL_W;
  localparam logic [EPD_W-1:0]  SEVEN        = 20'd7;

  // Stage 1: checked and decoded beat
  typedef struct packed {
    logic                ok;
    logic [YEAR_W-1:0]   yoff;    // year - 1980
    logic [YEAR_W-3:0]   nq4;     // (year - 1) / 4
    logic [Q100_W-1:0]   qn;      // (year - 1) / 100
    logic                leap;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MILLIS_W-1:0] millis;
  } chk_t;

  // Stage 2: day parts and time of day
  typedef struct packed {
    logic             ok;
    logic [EPD_W-1:0] days_year;
    logic [DIY_W-1:0] diy;
    logic [TOD_W-1:0] tod;
  } span_t;

  // Stage 3: day of epoch
  typedef struct packed {
    logic             ok;
    logic [EPD_W-1:0] epd;
    logic [TOD_W-1:0] tod;
  } epd_t;

  // Stage 4: week quotient
  typedef struct packed {
    logic             ok;
    logic [EPD_W-1:0] epd;
    logic [WQ_W-1:0]  week;
    logic [TOD_W-1:0] tod;
  } wq_t;

  // Days before the first of a month in a common year
  function automatic logic [DIY_W-1:0] cum_days(input logic [MONTH_W-1:0] month);
    logic [DIY_W-1:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Milliseconds at the start of a day of week
  function automatic logic [TOW_W-1:0] dow_ms(input logic [2:0] dow);
    logic [TOW_W-1:0] m;
    case (dow)
      3'd0:    m = 30'd0;
      3'd1:    m = 30'd86400000;
      3'd2:    m = 30'd172800000;
      3'd3:    m = 30'd259200000;
      3'd4:    m = 30'd345600000;
      3'd5:    m = 30'd432000000;
      3'd6:    m = 30'd518400000;
      default: m = 30'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/gctw_if.sv =====
// ----------------------------------------------------------------------------
// gctw_if: stream channels
// Valid/ready channels for calendar beats in and week/time-of-week beats out.
// ----------------------------------------------------------------------------
interface gctw_in_if;
  import gctw_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   cal_year;
  logic [MONTH_W-1:0]  cal_month;
  logic [DAY_W-1:0]    cal_day;
  logic [HOUR_W-1:0]   cal_hour;
  logic [MINUTE_W-1:0] cal_minute;
  logic [MILLIS_W-1:0] cal_millis;

  modport source (output valid, cal_year, cal_month, cal_day, cal_hour, cal_minute,
                  cal_millis, input ready);
  modport sink (input valid, cal_year, cal_month, cal_day, cal_hour, cal_minute,
                cal_millis, output ready);
endinterface

interface gctw_out_if;
  import gctw_pkg::*;

  logic              valid;
  logic              ready;
  logic              time_valid;
  logic [WEEK_W-1:0] week_number;
  logic [TOW_W-1:0]  week_millis;

  modport source (output valid, time_valid, week_number, week_millis, input ready);
  modport sink (input valid, time_valid, week_number, week_millis, output ready);
endinterface

// ===== rtl/gctw_decode.sv =====
// ----------------------------------------------------------------------------
// gctw_decode: range checks and year decode (stage 1)
// Checks every field, and splits the year into the quotients needed for the
// leap year count and the leap flag of the year itself.
// ----------------------------------------------------------------------------
module gctw_decode #(
  parameter int MAX_YEAR = gctw_pkg::MAX_YEAR_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  gctw_in_if.sink        in_if,
  output logic           dn_valid,
  output gctw_pkg::chk_t dn_data,
  input  logic           dn_ready
);
  import gctw_pkg::*;

  localparam logic [YEAR_W-1:0] YEAR_LIMIT = YEAR_W'(MAX_YEAR);

  logic                     valid_r;
  chk_t                     data_r;
  chk_t                     data_nxt;
  logic                     adv;
  logic [YEAR_W-1:0]        yprev;
  logic [YEAR_W+12:0]       prod_n;
  logic [YEAR_W+12:0]       prod_y;
  logic [Q100_W-1:0]        qy;
  logic                     div100;
  logic                     range_ok;

  // Advance when the stage is empty or its beat moves on
  assign adv         = !valid_r || dn_ready;
  assign in_if.ready = adv;

  // Decode the year and check ranges
  always_comb begin
    yprev    = in_if.cal_year - YEAR_W'(1);
    prod_n   = (YEAR_W+13)'(yprev) * (YEAR_W+13)'(DIV100_MUL);
    prod_y   = (YEAR_W+13)'(in_if.cal_year) * (YEAR_W+13)'(DIV100_MUL);
    qy       = prod_y[DIV100_SHIFT +: Q100_W];
    div100   = (in_if.cal_year == YEAR_W'(qy) * YEAR_W'(HUNDRED));
    range_ok = (in_if.cal_year >= EPOCH_YEAR) && (in_if.cal_year <= YEAR_LIMIT) &&
               (in_if.cal_month != '0) && (in_if.cal_month <= MONTH_DEC) &&
               (in_if.cal_day != '0) && (in_if.cal_hour <= HOUR_MAX) &&
               (in_if.cal_minute <= MINUTE_MAX) && (in_if.cal_millis < MS_LIMIT);

    data_nxt.ok     = range_ok;
    data_nxt.yoff   = in_if.cal_year - EPOCH_YEAR;
    data_nxt.nq4    = yprev[YEAR_W-1:2];
    data_nxt.qn     = prod_n[DIV100_SHIFT +: Q100_W];
    data_nxt.leap   = ((in_if.cal_year[1:0] == 2'b00) && !div100) ||
                      (div100 && (qy[1:0] == 2'b00));
    data_nxt.month  = in_if.cal_month;
    data_nxt.day    = in_if.cal_day;
    data_nxt.hour   = in_if.cal_hour;
    data_nxt.minute = in_if.cal_minute;
    data_nxt.millis = in_if.cal_millis;
  end

  // Hold valid state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_if.valid;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ===== rtl/gctw_days.sv =====
// ----------------------------------------------------------------------------
// gctw_days: day count since the GPS epoch (stages 2 and 3)
// Adds whole years, leap days, months and day of month, then shifts the count
// to GPS day zero and rejects dates before it.
// ----------------------------------------------------------------------------
module gctw_days (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  gctw_pkg::chk_t up_data,
  output logic           up_ready,
  output logic           dn_valid,
  output gctw_pkg::epd_t dn_data,
  input  logic           dn_ready
);
  import gctw_pkg::*;

  logic             s2_valid_r;
  span_t            s2_r;
  span_t            s2_nxt;
  logic             s3_valid_r;
  epd_t             s3_r;
  epd_t             s3_nxt;
  logic             adv2;
  logic             adv3;
  logic [LEAP_W-1:0] leaps;
  logic [EPD_W-1:0]  total;

  // Ready chain
  assign adv3     = !s3_valid_r || dn_ready;
  assign adv2     = !s2_valid_r || adv3;
  assign up_ready = adv2;

  // Stage 2: years, months and time of day
  always_comb begin
    leaps = LEAP_W'(up_data.nq4) - LEAP_W'(up_data.qn) +
            LEAP_W'(up_data.qn[Q100_W-1:2]) - LEAPS_EPOCH;
    s2_nxt.ok        = up_data.ok;
    s2_nxt.days_year = EPD_W'(up_data.yoff) * DAYS_YEAR + EPD_W'(leaps);
    s2_nxt.diy       = cum_days(up_data.month) +
                       DIY_W'(up_data.leap && (up_data.month > MONTH_FEB)) +
                       DIY_W'(up_data.day);
    s2_nxt.tod       = TOD_W'(up_data.hour) * MS_PER_HOUR +
                       TOD_W'(up_data.minute) * MS_PER_MIN +
                       TOD_W'(up_data.millis);
  end

  // Stage 3: total days, drop dates before day zero
  always_comb begin
    total      = s2_r.days_year + EPD_W'(s2_r.diy);
    s3_nxt.ok  = s2_r.ok && (total >= EPOCH_DAY);
    s3_nxt.epd = total - EPOCH_DAY;
    s3_nxt.tod = s2_r.tod;
  end

  // Hold valid state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (adv2) begin
        s2_valid_r <= up_valid;
      end
      if (adv3) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  // Load payloads
  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_r <= s2_nxt;
    end
    if (adv3) begin
      s3_r <= s3_nxt;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_data  = s3_r;

endmodule

// ===== rtl/gctw_tow.sv =====
// ----------------------------------------------------------------------------
// gctw_tow: week number and time of week (stages 4 and 5)
// Divides the day count by seven through a reciprocal multiply, then builds
// the time of week and drives the result channel from its output register.
// ----------------------------------------------------------------------------
module gctw_tow (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  input  gctw_pkg::epd_t up_data,
  output logic           up_ready,
  gctw_out_if.source     out_if
);
  import gctw_pkg::*;

  logic               s4_valid_r;
  wq_t                s4_r;
  wq_t                s4_nxt;
  logic               out_valid_r;
  logic               ok_r;
  logic [WEEK_W-1:0]  week_r;
  logic [TOW_W-1:0]   tow_r;
  logic [WEEK_W-1:0]  week_nxt;
  logic [TOW_W-1:0]   tow_nxt;
  logic               adv4;
  logic               adv5;
  logic [PROD7_W-1:0] prod;
  logic [EPD_W-1:0]   rem;

  // Ready chain
  assign adv5     = !out_valid_r || out_if.ready;
  assign adv4     = !s4_valid_r || adv5;
  assign up_ready = adv4;

  // Stage 4: days / 7 by reciprocal
  always_comb begin
    prod        = PROD7_W'(up_data.epd) * PROD7_W'(DIV7_MUL);
    s4_nxt.ok   = up_data.ok;
    s4_nxt.epd  = up_data.epd;
    s4_nxt.week = prod[DIV7_SHIFT +: WQ_W];
    s4_nxt.tod  = up_data.tod;
  end

  // Stage 5: day of week and time of week, zero when rejected
  always_comb begin
    rem = s4_r.epd - EPD_W'(s4_r.week) * SEVEN;
    if (s4_r.ok) begin
      week_nxt = s4_r.week[WEEK_W-1:0];
      tow_nxt  = dow_ms(rem[2:0]) + TOW_W'(s4_r.tod);
    end else begin
      week_nxt = '0;
      tow_nxt  = '0;
    end
  end

  // Hold valid state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv4) begin
        s4_valid_r <= up_valid;
      end
      if (adv5) begin
        out_valid_r <= s4_valid_r;
      end
    end
  end

  // Load payloads
  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_r <= s4_nxt;
    end
    if (adv5) begin
      ok_r   <= s4_r.ok;
      week_r <= week_nxt;
      tow_r  <= tow_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.time_valid  = ok_r;
  assign out_if.week_number = week_r;
  assign out_if.week_millis = tow_r;

endmodule

// ===== rtl/gps_calendar_to_week_tow_core.sv =====
// ----------------------------------------------------------------------------
// gps_calendar_to_week_tow_core: GPS calendar date to week and time of week
// Takes a date and time of day in GPS time, returns GPS week number and time
// of week in milliseconds, with a flag for beats that failed any check.
//
// Usage:
//   in_if  carries one calendar beat (year, month, day, hour, minute, ms).
//   out_if carries one result beat per input beat, in order: time_valid,
//          week_number and week_millis; rejected beats come out with zeros.
//   Both channels use valid/ready; a beat moves when both are high.
//   A result passes through five register stages: checks, day parts,
//   epoch day, divide by seven, output.
//   Throughput is one beat per cycle while out_if.ready stays high; each
//   stage has its own valid bit and a stage loads whenever it is empty or
//   its beat moves on.
//   When the receiver stalls, beats pack into the empty stages; in_if.ready
//   drops only once all five stages hold a beat. Nothing is lost or repeated.
//   Reset (rst_n low, synchronous) empties every stage; payload is not reset.
// ----------------------------------------------------------------------------
module gps_calendar_to_week_tow_core #(
  parameter int MAX_YEAR = gctw_pkg::MAX_YEAR_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gctw_in_if.sink    in_if,
  gctw_out_if.source out_if
);
  import gctw_pkg::*;

  logic  chk_valid;
  chk_t  chk_data;
  logic  chk_ready;
  logic  epd_valid;
  epd_t  epd_data;
  logic  epd_ready;

  // Stage 1: checks and year decode
  gctw_decode #(
    .MAX_YEAR (MAX_YEAR)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .dn_valid (chk_valid),
    .dn_data  (chk_data),
    .dn_ready (chk_ready)
  );

  // Stages 2 and 3: day count since epoch
  gctw_days u_days (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chk_valid),
    .up_data  (chk_data),
    .up_ready (chk_ready),
    .dn_valid (epd_valid),
    .dn_data  (epd_data),
    .dn_ready (epd_ready)
  );

  // Stages 4 and 5: week, time of week, output register
  gctw_tow u_tow (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (epd_valid),
    .up_data  (epd_data),
    .up_ready (epd_ready),
    .out_if   (out_if)
  );

  // Rejected beats carry zero payload
  a_zero_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.time_valid |-> (out_if.week_number == '0) &&
                                           (out_if.week_millis == '0))
    else $error("rejected beat with nonzero payload");

  // Time of week stays inside one week plus a leap second
  a_tow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.time_valid |-> out_if.week_millis < 30'd604801000)
    else $error("time of week out of range");

  // Input backpressure only when the output is blocked
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> out_if.valid && !out_if.ready)
    else $error("input stalled while output is free");

  // The first stage accepts after reset
  a_ready_reset: assert property (@(posedge clk)
    !rst_n |=> in_if.ready)
    else $error("input not ready after reset");

endmodule

// ===== tb/sv/gps_calendar_to_week_tow_core_test.sv =====
// ----------------------------------------------------------------------------
// gps_calendar_to_week_tow_core_test: self-checking bench for the GPS
// calendar to week / time-of-week core
// Feeds calendar beats through the valid/ready input channel and predicts
// the week number and time of week of each beat. Results are checked in
// order against that prediction. The stimulus opens with epoch, leap, range
// and year-limit corner beats and then moves to random beats. Random gaps
// and stalls, long receiver holds and drain pauses exercise the handshake.
// ----------------------------------------------------------------------------
module gps_calendar_to_week_tow_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gctw_pkg::*;

  localparam int MAX_YEAR  = MAX_YEAR_DEF;
  localparam int N_BEATS   = 1150;
  localparam int LONG_HOLD = 80;
  localparam int DRAIN_AT  = 600;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [MILLIS_W-1:0] millis;
  } cal_beat_t;

  typedef struct packed {
    logic              time_valid;
    logic [WEEK_W-1:0] week_number;
    logic [TOW_W-1:0]  week_millis;
  } gps_time_t;

  // Predict GPS week / time of week per input beat, check results in order
  class gps_time_scoreboard;
    gps_time_t   expected_times[$];
    int unsigned errors;

    static function int unsigned leaps_through(int unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function gps_time_t gps_time_of(cal_beat_t c);
      int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      int unsigned y;
      int unsigned days;
      bit          leap;
      gps_time_t   r;
      r = '0;
      y = c.year;
      if (y < 1980 || y > MAX_YEAR || c.month < 1 || c.month > 12 || c.day < 1 ||
          c.hour > 23 || c.minute > 59 || c.millis >= 61000)
        return r;
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      days = 365 * (y - 1980) + leaps_through(y - 1) - leaps_through(1979);
      for (int m = 1; m < c.month; m++)
        days += (m == 2 && leap) ? 29 : month_days[m-1];
      days += c.day;
      // reject dates before the epoch day
      if (days < 6)
        return r;
      days -= 6;
      r.time_valid  = 1'b1;
      r.week_number = WEEK_W'(days / 7);
      r.week_millis = TOW_W'((days % 7) * 86400000 + c.hour * 3600000 + c.minute * 60000
                             + c.millis);
      return r;
    endfunction

    function void note_beat(cal_beat_t c);
      expected_times = {expected_times, gps_time_of(c)};
    endfunction

    function void check_beat(gps_time_t got);
      gps_time_t want;
      if (expected_times.size() == 0) begin
        $error("result beat with nothing pending: valid %0d week %0d ms %0d",
               got.time_valid, got.week_number, got.week_millis);
        errors++;
        return;
      end
      want = expected_times.pop_front();
      if (got.time_valid !== want.time_valid) begin
        $error("time_valid: expected %0d, got %0d", want.time_valid, got.time_valid);
        errors++;
      end
      if (got.week_number !== want.week_number) begin
        $error("week_number: expected %0d, got %0d", want.week_number, got.week_number);
        errors++;
      end
      if (got.week_millis !== want.week_millis) begin
        $error("week_millis: expected %0d, got %0d", want.week_millis, got.week_millis);
        errors++;
      end
    endfunction

    function int pending();
      return expected_times.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gctw_in_if  in_if ();
  gctw_out_if out_if ();

  gps_time_scoreboard sb = new;

  gps_calendar_to_week_tow_core #(
    .MAX_YEAR(MAX_YEAR)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic cal_beat_t cal_beat(int y, int mo, int d, int h, int mi, int ms);
    cal_beat_t c;
    c.year   = YEAR_W'(y);
    c.month  = MONTH_W'(mo);
    c.day    = DAY_W'(d);
    c.hour   = HOUR_W'(h);
    c.minute = MINUTE_W'(mi);
    c.millis = MILLIS_W'(ms);
    return c;
  endfunction

  // Mostly well-formed dates, with epoch, year-limit, leap-second, one-bad-field and raw beats
  function automatic cal_beat_t draw_calendar();
    cal_beat_t   c;
    int unsigned sel;
    logic [63:0] raw;
    sel = $urandom_range(0, 99);
    c = cal_beat($urandom_range(1980, MAX_YEAR), $urandom_range(1, 12),
                 $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                 $urandom_range(0, 60999));
    if (sel < 20) begin
      raw = {$urandom(), $urandom()};
      c   = raw[$bits(cal_beat_t)-1:0];
    end else if (sel < 30) begin
      c.year  = YEAR_W'(1980);
      c.month = MONTH_W'(1);
      c.day   = DAY_W'($urandom_range(1, 10));
    end else if (sel < 38) begin
      c.year = YEAR_W'($urandom_range(MAX_YEAR - 1, MAX_YEAR + 1));
    end else if (sel < 50) begin
      case ($urandom_range(0, 5))
        0: c.year   = ($urandom_range(0, 1) != 0) ?
                      YEAR_W'($urandom_range(MAX_YEAR + 1, 4095)) :
                      YEAR_W'($urandom_range(0, 1979));
        1: c.month  = ($urandom_range(0, 1) != 0) ? MONTH_W'($urandom_range(13, 15)) : '0;
        2: c.day    = '0;
        3: c.hour   = HOUR_W'($urandom_range(24, 31));
        4: c.minute = MINUTE_W'($urandom_range(60, 63));
        default: c.millis = MILLIS_W'($urandom_range(61000, 65535));
      endcase
    end else if (sel < 56) begin
      c.millis = MILLIS_W'($urandom_range(60000, 60999));
    end
    return c;
  endfunction

  // Sender idle cycles: no gaps in every fourth stretch of 50 beats
  function automatic int unsigned sender_gap(int unsigned idx);
    if ((idx / 50) % 4 == 1)
      return 0;
    return $urandom_range(0, 10);
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(cal_beat_t c);
    in_if.valid      <= 1'b1;
    in_if.cal_year   <= c.year;
    in_if.cal_month  <= c.month;
    in_if.cal_day    <= c.day;
    in_if.cal_hour   <= c.hour;
    in_if.cal_minute <= c.minute;
    in_if.cal_millis <= c.millis;
    do @(posedge clk); while (!in_if.ready);
    sb.note_beat(c);
  endtask

  // Drop valid and idle for the drawn number of cycles
  task automatic idle_sender(int unsigned gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every pending result is back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    cal_beat_t   corner[$];
    int unsigned idx;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.cal_year   <= '0;
    in_if.cal_month  <= '0;
    in_if.cal_day    <= '0;
    in_if.cal_hour   <= '0;
    in_if.cal_minute <= '0;
    in_if.cal_millis <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // epoch edges and leap second
    corner = {corner, cal_beat(1980, 1, 6, 0, 0, 0)};
    corner = {corner, cal_beat(1980, 1, 5, 23, 59, 60999)};
    corner = {corner, cal_beat(1980, 1, 1, 0, 0, 0)};
    corner = {corner, cal_beat(1980, 1, 6, 23, 59, 60999)};
    // year limits
    corner = {corner, cal_beat(1979, 12, 31, 0, 0, 0)};
    corner = {corner, cal_beat(0, 0, 0, 0, 0, 0)};
    corner = {corner, cal_beat(MAX_YEAR, 12, 31, 23, 59, 60999)};
    corner = {corner, cal_beat(MAX_YEAR + 1, 1, 1, 0, 0, 0)};
    corner = {corner, cal_beat(4095, 15, 31, 31, 63, 65535)};
    // single fields out of range
    corner = {corner, cal_beat(2000, 0, 1, 0, 0, 0)};
    corner = {corner, cal_beat(2000, 13, 1, 0, 0, 0)};
    corner = {corner, cal_beat(2000, 2, 0, 0, 0, 0)};
    corner = {corner, cal_beat(2024, 6, 15, 24, 0, 0)};
    corner = {corner, cal_beat(2024, 6, 15, 0, 60, 0)};
    corner = {corner, cal_beat(2024, 6, 15, 0, 0, 61000)};
    // leap rules and days past the end of a month
    corner = {corner, cal_beat(2000, 2, 29, 12, 30, 30000)};
    corner = {corner, cal_beat(2100, 2, 31, 6, 0, 1)};
    corner = {corner, cal_beat(2100, 3, 1, 0, 0, 0)};
    corner = {corner, cal_beat(1980, 2, 31, 0, 0, 0)};
    corner = {corner, cal_beat(2024, 12, 31, 23, 59, 59999)};
    corner = {corner, cal_beat(1981, 1, 1, 0, 0, 0)};
    // week rollover
    corner = {corner, cal_beat(2019, 4, 6, 23, 59, 59999)};
    corner = {corner, cal_beat(2019, 4, 7, 0, 0, 0)};

    foreach (corner[i]) begin
      send_beat(corner[i]);
      idle_sender($urandom_range(0, 10));
    end
    drain_results();

    idx = corner.size();
    while (idx < N_BEATS) begin
      send_beat(draw_calendar());
      idx++;
      if (idx == DRAIN_AT)
        drain_results();
      else
        idle_sender(sender_gap(idx));
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, quiet stretches and two long holds
  initial begin
    int unsigned seen;
    int unsigned stall;
    gps_time_t   got;
    seen = 0;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_if.ready <= 1'b1;
    forever begin
      do @(posedge clk); while (!out_if.valid);
      got.time_valid  = out_if.time_valid;
      got.week_number = out_if.week_number;
      got.week_millis = out_if.week_millis;
      sb.check_beat(got);
      seen++;
      if (seen == 60 || seen == 700)
        stall = LONG_HOLD;
      else if ((seen / 40) % 3 == 0)
        stall = 0;
      else
        stall = $urandom_range(0, 10);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  // Hard stop
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gctw_pkg.sv
rtl/gctw_if.sv
rtl/gctw_decode.sv
rtl/gctw_days.sv
rtl/gctw_tow.sv
rtl/gps_calendar_to_week_tow_core.sv
tb/sv/gps_calendar_to_week_tow_core_test.sv
